FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the list merge block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list merge package
// Command codes, controller states and the control bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package slm_pkg;

   // Width of one list element.
   localparam int unsigned DATA_W = 32;

   // Request kinds carried on the request channel.
   typedef enum logic [1:0] {
      KIND_APPEND_A = 2'd0,
      KIND_APPEND_B = 2'd1,
      KIND_MERGE    = 2'd2
   } kind_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic append_a;
      logic append_b;
      logic emit;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit_last;
   } status_type;

endpackage

FILE: rtl/slm_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted list merge controller
// Accepts requests while idle, issues append commands and steps the merge
// run one result per cycle until the datapath reports the final element.
// ----------------------------------------------------------------------------
module slm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_kind,
   input  slm_pkg::status_type  status,
   output logic                 busy,
   output slm_pkg::cmd_type     cmd
);

   slm_pkg::state_type state_ff;
   slm_pkg::state_type state_in;
   logic               accept;

   // A request is taken whenever the block is idle.
   assign accept = start && (state_ff == slm_pkg::ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a merge request starts a run, the final result ends it.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slm_pkg::ST_IDLE: begin
            if (accept && (req_kind == slm_pkg::KIND_MERGE)) begin
               state_in = slm_pkg::ST_RUN;
            end
         end
         slm_pkg::ST_RUN: begin
            if (status.emit_last) begin
               state_in = slm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slm_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: append commands while idle, one emit per cycle while running.
   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      case (state_ff)
         slm_pkg::ST_IDLE: begin
            cmd.append_a = accept && (req_kind == slm_pkg::KIND_APPEND_A);
            cmd.append_b = accept && (req_kind == slm_pkg::KIND_APPEND_B);
         end
         slm_pkg::ST_RUN: begin
            busy      = 1'b1;
            cmd.emit  = 1'b1;
            cmd.clear = status.emit_last;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/slm_datapath.sv
// ----------------------------------------------------------------------------
// Sorted list merge datapath
// Holds both list stores, their fill counts and read pointers, compares the
// two list heads and registers each merged result.
// ----------------------------------------------------------------------------
module slm_datapath #(
   parameter int unsigned LIST_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  slm_pkg::cmd_type                   cmd,
   input  logic signed [slm_pkg::DATA_W-1:0]  req_value,
   output slm_pkg::status_type                status,
   output logic                               rsp_valid,
   output logic signed [slm_pkg::DATA_W-1:0]  rsp_merged_value,
   output logic                               rsp_empty_res,
   output logic                               rsp_overflow,
   output logic                               rsp_last
);

   localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
   localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic signed [slm_pkg::DATA_W-1:0] store_a [LIST_DEPTH];
   logic signed [slm_pkg::DATA_W-1:0] store_b [LIST_DEPTH];

   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] ptr_a_ff, ptr_a_in;
   logic [CW-1:0] ptr_b_ff, ptr_b_in;
   logic          overflow_ff, overflow_in;

   logic signed [slm_pkg::DATA_W-1:0] head_a_ff;
   logic signed [slm_pkg::DATA_W-1:0] head_b_ff;

   logic          room_a, room_b;
   logic [AW-1:0] rd_idx_a, rd_idx_b;
   logic          a_left, b_left, take_a;
   logic [CW:0]   total;
   logic [CW:0]   position;
   logic          total_zero;

   logic                              valid_ff;
   logic signed [slm_pkg::DATA_W-1:0] value_ff, value_in;
   logic                              empty_ff;
   logic                              ovf_out_ff;
   logic                              last_ff;

   // Head comparison: take A while it has elements and is not above B.
   assign room_a     = count_a_ff < CW'(LIST_DEPTH);
   assign room_b     = count_b_ff < CW'(LIST_DEPTH);
   assign a_left     = ptr_a_ff < count_a_ff;
   assign b_left     = ptr_b_ff < count_b_ff;
   assign take_a     = a_left && (!b_left || (head_a_ff <= head_b_ff));
   assign total      = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign position   = {1'b0, ptr_a_ff} + {1'b0, ptr_b_ff} + (CW+1)'(1);
   assign total_zero = (total == '0);

   // The final result is the single empty one or the last stored element.
   assign status.emit_last = cmd.emit && (total_zero || (position == total));

   // Count, pointer and flag updates.
   always_comb begin
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      ptr_a_in    = ptr_a_ff;
      ptr_b_in    = ptr_b_ff;
      overflow_in = overflow_ff;
      if (cmd.append_a) begin
         if (room_a) begin
            count_a_in = count_a_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.append_b) begin
         if (room_b) begin
            count_b_in = count_b_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.emit && !total_zero) begin
         if (take_a) begin
            ptr_a_in = ptr_a_ff + CW'(1);
         end else begin
            ptr_b_in = ptr_b_ff + CW'(1);
         end
      end
      if (cmd.clear) begin
         count_a_in  = '0;
         count_b_in  = '0;
         ptr_a_in    = '0;
         ptr_b_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         ptr_a_ff    <= '0;
         ptr_b_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         ptr_a_ff    <= ptr_a_in;
         ptr_b_ff    <= ptr_b_in;
         overflow_ff <= overflow_in;
      end
   end

   // Read addresses follow the next pointer so each head stays current.
   assign rd_idx_a = (ptr_a_in < CW'(LIST_DEPTH)) ? ptr_a_in[AW-1:0] : '0;
   assign rd_idx_b = (ptr_b_in < CW'(LIST_DEPTH)) ? ptr_b_in[AW-1:0] : '0;

   // List stores: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (cmd.append_a && room_a) begin
         store_a[count_a_ff[AW-1:0]] <= req_value;
      end
      head_a_ff <= store_a[rd_idx_a];
   end

   always_ff @(posedge clock) begin
      if (cmd.append_b && room_b) begin
         store_b[count_b_ff[AW-1:0]] <= req_value;
      end
      head_b_ff <= store_b[rd_idx_b];
   end

   // Result value: zero for an empty merge, else the chosen head.
   always_comb begin
      if (total_zero) begin
         value_in = '0;
      end else if (take_a) begin
         value_in = head_a_ff;
      end else begin
         value_in = head_b_ff;
      end
   end

   // Result register: the strobe is reset, the payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         value_ff   <= value_in;
         empty_ff   <= total_zero;
         ovf_out_ff <= overflow_ff;
         last_ff    <= status.emit_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_merged_value = value_ff;
   assign rsp_empty_res    = empty_ff;
   assign rsp_overflow     = ovf_out_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: rtl/sorted_list_merge.sv
// ----------------------------------------------------------------------------
// Sorted list merge
// Two lists of signed values are appended one element at a time; a merge
// request streams both lists out as one ascending run, A first on ties.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Handshake
// request   req_kind, req_value                     start high, busy low
// result    rsp_merged_value, rsp_empty_res,        rsp_valid, one cycle
//           rsp_overflow, rsp_last
//
// An append leaves busy low, so the next request may follow.
// A merge holds busy until the final element is emitted, one result per
// cycle, set by the single head compare; each result is registered in the cycle after the compare.
// Reset empties both lists and clears the overflow flag; no sweep is needed.
// Results cannot be held off, so the run never stalls once it has started.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_list_merge #(
   parameter int unsigned LIST_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic signed [slm_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   output logic signed [slm_pkg::DATA_W-1:0]  rsp_merged_value,
   output logic                               rsp_empty_res,
   output logic                               rsp_overflow,
   output logic                               rsp_last
);

   slm_pkg::cmd_type    cmd;
   slm_pkg::status_type status;

   // Controller: request acceptance and run sequencing.
   slm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // Datapath: list stores, head compare and result register.
   slm_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_merged_value (rsp_merged_value),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflow     (rsp_overflow),
      .rsp_last         (rsp_last)
   );

   // A run of results is unbroken until its final beat.
   `ASSERT_CLK(a_run_unbroken, clock, reset, (rsp_valid && !rsp_last) |=> rsp_valid, "merge run broken before last beat")

   // The empty result is always the only and final beat.
   `ASSERT_NEVER(a_empty_is_last, clock, reset, rsp_valid && rsp_empty_res && !rsp_last, "empty result without last")

   // An accepted merge request makes the block busy in the next cycle.
   `ASSERT_CLK(a_merge_busy, clock, reset, (start && !busy && (req_kind == slm_pkg::KIND_MERGE)) |=> busy, "merge accepted but block not busy")

   // Every result beat comes from a cycle in which a run was active.
   `ASSERT_CLK(a_valid_from_run, clock, reset, rsp_valid |-> $past(busy), "result beat outside a merge run")

endmodule

FILE: dv/sorted_list_merge_tb.sv
// ----------------------------------------------------------------------------
// Sorted list merge testbench
// Loads two lists one beat at a time and merges them. Every merge run is
// predicted beat by beat and checked against the block's output. A short
// table covers reset, extremes, ties, unsorted lists and the unused kind.
// Random groups of sorted and unsorted lists then follow, overflow among
// them, with random gaps from the sender.
// ----------------------------------------------------------------------------
module sorted_list_merge_tb;

   localparam int unsigned DEPTH      = 32;
   localparam int          STALL_MAX  = 2000;
   localparam int          ITEM_GOAL  = 150;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;

   // One result beat of a merge run.
   typedef struct packed {
      logic signed [slm_pkg::DATA_W-1:0] value;
      logic                              empty_res;
      logic                              overflow;
      logic                              last;
   } merge_beat_type;

   // One row of the directed table.
   typedef struct packed {
      logic [1:0]                        kind;
      logic signed [slm_pkg::DATA_W-1:0] value;
      logic                              typed;
      merge_beat_type                    beat;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [1:0]                         req_kind = '0;
   logic signed [slm_pkg::DATA_W-1:0]  req_value = '0;
   logic                               rsp_valid;
   logic signed [slm_pkg::DATA_W-1:0]  rsp_merged_value;
   logic                               rsp_empty_res;
   logic                               rsp_overflow;
   logic                               rsp_last;

   // Hand-typed expectation travelling with the request beat.
   logic                               typed_row = 1'b0;
   merge_beat_type                     typed_beat = '0;

   // Predictor state.
   logic signed [slm_pkg::DATA_W-1:0]  list_a [DEPTH];
   logic signed [slm_pkg::DATA_W-1:0]  list_b [DEPTH];
   int unsigned                        fill_a = 0;
   int unsigned                        fill_b = 0;
   bit                                 dropped_seen = 1'b0;
   merge_beat_type                     run_beats [$];

   merge_beat_type                     expected_run_q [$];
   int                                 error_count = 0;
   int                                 stall_cycles = 0;
   int                                 random_items = 0;
   bit                                 sender_gaps = 1'b1;
   stim_row_type                       directed_rows [23];

   sorted_list_merge #(.LIST_DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_merged_value (rsp_merged_value),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflow     (rsp_overflow),
      .rsp_last         (rsp_last)
   );

   // Clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one accepted request to the predictor; a merge leaves its run
   // in run_beats.
   task automatic predict_list_op(input logic [1:0] kind,
                                  input logic signed [slm_pkg::DATA_W-1:0] value);
      int unsigned    ia;
      int unsigned    ib;
      int unsigned    total;
      merge_beat_type beat;
      ia = 0;
      ib = 0;
      run_beats.delete();
      case (kind)
         slm_pkg::KIND_APPEND_A: begin
            if (fill_a < DEPTH) begin
               list_a[fill_a] = value;
               fill_a++;
            end else begin
               dropped_seen = 1'b1;
            end
         end
         slm_pkg::KIND_APPEND_B: begin
            if (fill_b < DEPTH) begin
               list_b[fill_b] = value;
               fill_b++;
            end else begin
               dropped_seen = 1'b1;
            end
         end
         slm_pkg::KIND_MERGE: begin
            total = fill_a + fill_b;
            if (total == 0) begin
               run_beats.push_back('{'0, 1'b1, dropped_seen, 1'b1});
            end
            // Two-pointer walk over the heads; A wins on a tie.
            while (ia < fill_a || ib < fill_b) begin
               if (ia < fill_a && (ib >= fill_b || list_a[ia] <= list_b[ib])) begin
                  beat.value = list_a[ia];
                  ia++;
               end else begin
                  beat.value = list_b[ib];
                  ib++;
               end
               beat.empty_res = 1'b0;
               beat.overflow  = dropped_seen;
               beat.last      = (ia + ib == total);
               run_beats.push_back(beat);
            end
            fill_a       = 0;
            fill_b       = 0;
            dropped_seen = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [slm_pkg::DATA_W-1:0] want,
                              input logic [slm_pkg::DATA_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Request and result monitor: predicts on each accepted beat, checks each
   // result beat, and stops the run if nothing moves for too long. A result
   // that nothing predicted does not count as movement.
   always @(posedge clock) begin
      merge_beat_type want;
      bit             moved;
      if (!reset) begin
         moved = start && !busy;
         if (start && !busy) begin
            predict_list_op(req_kind, req_value);
            if (typed_row) begin
               expected_run_q.push_back(typed_beat);
            end else begin
               foreach (run_beats[i]) expected_run_q.push_back(run_beats[i]);
            end
         end
         if (rsp_valid) begin
            if (expected_run_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual value %0h last %0b",
                        $time, rsp_merged_value, rsp_last);
            end else begin
               moved = 1'b1;
               want = expected_run_q.pop_front();
               check_field("merged_value", want.value, rsp_merged_value);
               check_field("empty_res", want.empty_res, rsp_empty_res);
               check_field("overflow", want.overflow, rsp_overflow);
               check_field("last", want.last, rsp_last);
            end
         end
         if (moved) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_MAX) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_MAX);
            $display("sorted_list_merge_tb: FAIL");
            $finish;
         end
      end
   end

   // Drives one request beat and returns at the edge that accepts it.
   task automatic send_request(input logic [1:0] kind,
                               input logic [slm_pkg::DATA_W-1:0] value,
                               input logic typed, input merge_beat_type beat);
      while (sender_gaps && $urandom_range(0, 99) < 28) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_kind   <= kind;
      req_value  <= value;
      typed_row  <= typed;
      typed_beat <= beat;
      do @(posedge clock); while (busy);
      if (kind != KIND_UNUSED) random_items++;
   endtask

   // Holds the sender off until every predicted result beat has arrived.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_run_q.size() != 0) @(posedge clock);
   endtask

   function automatic int draw_value();
      if ($urandom_range(0, 99) < 40) return int'($urandom);
      return int'($urandom_range(0, 40)) - 20;
   endfunction

   // Fills both lists in random interleaving, with the odd unused-kind beat,
   // then merges them.
   task automatic run_list_pair(input int a_n, input int b_n, input bit keep_order);
      int a_vals [$];
      int b_vals [$];
      for (int i = 0; i < a_n; i++) a_vals.push_back(draw_value());
      for (int i = 0; i < b_n; i++) b_vals.push_back(draw_value());
      if (keep_order) begin
         a_vals.sort();
         b_vals.sort();
      end
      while (a_vals.size() + b_vals.size() != 0) begin
         if ($urandom_range(0, 19) == 0) send_request(KIND_UNUSED, $urandom, 1'b0, '0);
         if (b_vals.size() == 0 || (a_vals.size() != 0 && $urandom_range(0, 1) == 0)) begin
            send_request(slm_pkg::KIND_APPEND_A, a_vals.pop_front(), 1'b0, '0);
         end else begin
            send_request(slm_pkg::KIND_APPEND_B, b_vals.pop_front(), 1'b0, '0);
         end
      end
      send_request(slm_pkg::KIND_MERGE, $urandom, 1'b0, '0);
   endtask

   // Stimulus.
   initial begin
      int group;
      int roll;
      directed_rows = '{
         // Merge straight after reset gives the single empty result.
         '{slm_pkg::KIND_MERGE,    32'h5A5A5A5A, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b1}},
         '{KIND_UNUSED,            32'hFFFFFFFF, 1'b0, '0},
         '{slm_pkg::KIND_APPEND_A, 32'h80000000, 1'b0, '0},
         '{slm_pkg::KIND_MERGE,    32'hFFFFFFFF, 1'b1, '{32'h80000000, 1'b0, 1'b0, 1'b1}},
         '{slm_pkg::KIND_APPEND_B, 32'h7FFFFFFF, 1'b0, '0},
         '{slm_pkg::KIND_MERGE,    32'h00000000, 1'b1, '{32'h7FFFFFFF, 1'b0, 1'b0, 1'b1}},
         // Ties between the lists, A taken first.
         '{slm_pkg::KIND_APPEND_A, -32'sd5,      1'b0, '0},
         '{slm_pkg::KIND_APPEND_A, 32'sd3,       1'b0, '0},
         '{slm_pkg::KIND_APPEND_B, 32'sd3,       1'b0, '0},
         '{slm_pkg::KIND_APPEND_A, 32'sd3,       1'b0, '0},
         '{slm_pkg::KIND_APPEND_B, 32'sd100,     1'b0, '0},
         '{KIND_UNUSED,            32'sd12345,   1'b0, '0},
         '{slm_pkg::KIND_MERGE,    32'h00000000, 1'b0, '0},
         // Unsorted list A.
         '{slm_pkg::KIND_APPEND_A, 32'sd10,      1'b0, '0},
         '{slm_pkg::KIND_APPEND_A, -32'sd1,      1'b0, '0},
         '{slm_pkg::KIND_APPEND_B, 32'sd5,       1'b0, '0},
         '{slm_pkg::KIND_MERGE,    32'h00000000, 1'b0, '0},
         // B runs out first and A drains.
         '{slm_pkg::KIND_APPEND_A, 32'sd50,      1'b0, '0},
         '{slm_pkg::KIND_APPEND_B, 32'sd1,       1'b0, '0},
         '{slm_pkg::KIND_APPEND_B, 32'sd2,       1'b0, '0},
         '{slm_pkg::KIND_MERGE,    32'h00000000, 1'b0, '0},
         '{slm_pkg::KIND_APPEND_B, -32'sd7,      1'b0, '0},
         '{slm_pkg::KIND_MERGE,    32'h00000000, 1'b1, '{-32'sd7, 1'b0, 1'b0, 1'b1}}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].kind, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].beat);
      end
      wait_drained();

      // Random groups: an overflowing A and two full lists come first; a
      // stretch of groups then runs with no sender gaps and no draining.
      // The item count carries on from the directed rows.
      group = 0;
      while (random_items < ITEM_GOAL) begin
         sender_gaps = !(group >= 2 && group < 6);
         case (group)
            0: run_list_pair(34, 2, 1'b1);
            1: run_list_pair(32, 32, 1'b1);
            default: begin
               roll = $urandom_range(0, 99);
               if (roll < 5) begin
                  run_list_pair($urandom_range(0, 3), $urandom_range(30, 35), 1'b1);
               end else begin
                  run_list_pair($urandom_range(0, 6), $urandom_range(0, 6), roll >= 20);
               end
            end
         endcase
         if (group == 1 || (sender_gaps && $urandom_range(0, 3) == 0)) wait_drained();
         group++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_run_q.size() == 0) begin
         $display("sorted_list_merge_tb: PASS");
      end else begin
         $display("sorted_list_merge_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: sorted_list_merge.f
+incdir+rtl
rtl/slm_pkg.sv
rtl/slm_ctrl.sv
rtl/slm_datapath.sv
rtl/sorted_list_merge.sv
dv/sorted_list_merge_tb.sv
